FILE: rtl/rbol_pkg.sv
`default_nettype none

package rbol_pkg;

  // Ring geometry
  localparam int DEPTH = 10;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths
  localparam int HANDLE_W = 32;
  localparam int SIZE_W   = 16;
  localparam int OFFS_W   = 20;
  localparam int ENTRY_W  = HANDLE_W + SIZE_W;

  // Item opcodes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic                opcode;
    logic [HANDLE_W-1:0] entry_handle;
    logic [SIZE_W-1:0]   entry_size;
    logic [OFFS_W-1:0]   find_offset;
  } rbol_in_t;

  typedef struct packed {
    logic                found;
    logic [HANDLE_W-1:0] found_handle;
    logic [SIZE_W-1:0]   found_size;
    logic [SIZE_W-1:0]   byte_offset;
    logic                overwrote;
  } rbol_out_t;

  // Launch of a find walk
  typedef struct packed {
    logic              start;
    idx_t              start_idx;
    cnt_t              count;
    logic [OFFS_W-1:0] offset;
  } rbol_walk_cmd_t;

  // Wrap an index at the end of the ring
  function automatic idx_t rbol_next(input idx_t idx);
    rbol_next = (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + idx_t'(1);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rbol_ram.sv
`default_nettype none

module rbol_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rbol_walk.sv
`default_nettype none

module rbol_walk (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire rbol_pkg::rbol_walk_cmd_t cmd,
  output logic                          busy,
  output logic                          ram_re,
  output rbol_pkg::idx_t                ram_raddr,
  input  wire logic [rbol_pkg::ENTRY_W-1:0] ram_rdata,
  output logic                          res_valid,
  output rbol_pkg::rbol_out_t           res,
  input  wire logic                     res_ready
);
  import rbol_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  idx_t              idx_r, idx_nxt;
  cnt_t              left_r, left_nxt;
  logic [OFFS_W-1:0] rem_r, rem_nxt;
  rbol_out_t         res_r, res_nxt;

  logic [HANDLE_W-1:0] cur_handle;
  logic [SIZE_W-1:0]   cur_size;
  logic                hit;

  assign cur_handle = ram_rdata[ENTRY_W-1:SIZE_W];
  assign cur_size   = ram_rdata[SIZE_W-1:0];
  assign hit        = (rem_r < OFFS_W'(cur_size));

  // Step through one entry per cycle, prefetching the next slot
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    left_nxt  = left_r;
    rem_nxt   = rem_r;
    res_nxt   = res_r;
    ram_re    = 1'b0;
    ram_raddr = rbol_next(idx_r);
    case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          ram_re    = 1'b1;
          ram_raddr = cmd.start_idx;
          idx_nxt   = cmd.start_idx;
          left_nxt  = cmd.count;
          rem_nxt   = cmd.offset;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (hit) begin
          res_nxt.found        = 1'b1;
          res_nxt.found_handle = cur_handle;
          res_nxt.found_size   = cur_size;
          res_nxt.byte_offset  = rem_r[SIZE_W-1:0];
          res_nxt.overwrote    = 1'b0;
          state_nxt            = ST_DONE;
        end else if (left_r == CNT_W'(1)) begin
          res_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          ram_re    = 1'b1;
          idx_nxt   = rbol_next(idx_r);
          left_nxt  = left_r - cnt_t'(1);
          rem_nxt   = rem_r - OFFS_W'(cur_size);
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Walk payload
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    left_r <= left_nxt;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

  a_walk_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (left_r != '0))
    else $error("walk running with no entries left");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && state_r == ST_IDLE) |=> (state_r == ST_WALK))
    else $error("walk did not start");

  a_done_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_r.found) |-> (res_r.byte_offset < res_r.found_size))
    else $error("found offset outside entry");

endmodule

`default_nettype wire

FILE: rtl/ring_buffer_offset_lookup.sv
// Channel  Direction  Handshake               Payload
// in_      input      in_valid / in_ready     rbol_in_t  (opcode, handle, size, offset)
// out_     output     out_valid / out_ready   rbol_out_t (found, handle, size, offset, overwrote)
//
// An add writes the entry and loads its result into the output register.
// A find on an empty ring loads a not-found result into the output register; otherwise it
// reads one stored entry per cycle from the registered entry RAM until the byte falls inside
// an entry or the stored entries run out.
// Reset (rst_n, synchronous, active low) clears the indices, full flag and out_valid; the RAM
// keeps no reset. in_ready is low while a find walks and while a full output register stalls.
`default_nettype none

module ring_buffer_offset_lookup (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rbol_pkg::rbol_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rbol_pkg::rbol_out_t      out_data
);
  import rbol_pkg::*;

  idx_t      wr_idx_r, wr_idx_nxt;
  idx_t      rd_idx_r, rd_idx_nxt;
  logic      full_r, full_nxt;
  logic      out_valid_r, out_valid_nxt;
  rbol_out_t out_data_r, out_data_nxt;

  logic           in_acc;
  logic           out_free;
  cnt_t           count;
  rbol_walk_cmd_t cmd;
  logic           walk_busy;
  logic           ram_re;
  idx_t           ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic           res_valid;
  rbol_out_t      res;
  logic           res_ready;
  logic           ram_we;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !walk_busy && out_free;
  assign in_acc   = in_valid && in_ready;

  // Number of stored entries
  always_comb begin
    if (full_r) begin
      count = CNT_W'(DEPTH);
    end else if (wr_idx_r >= rd_idx_r) begin
      count = CNT_W'(wr_idx_r) - CNT_W'(rd_idx_r);
    end else begin
      count = CNT_W'(wr_idx_r) + CNT_W'(DEPTH) - CNT_W'(rd_idx_r);
    end
  end

  assign ram_we = in_acc && (in_data.opcode == OP_ADD);

  // Launch a walk for a find on a non-empty ring
  assign cmd.start     = in_acc && (in_data.opcode == OP_FIND) && (count != '0);
  assign cmd.start_idx = rd_idx_r;
  assign cmd.count     = count;
  assign cmd.offset    = in_data.find_offset;

  assign res_ready = res_valid && out_free;

  // Advance ring indices and load results
  always_comb begin
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (ram_we) begin
      rd_idx_nxt = full_r ? rbol_next(rd_idx_r) : rd_idx_r;
      wr_idx_nxt = rbol_next(wr_idx_r);
      if (wr_idx_nxt == rd_idx_nxt) begin
        full_nxt = 1'b1;
      end
      out_valid_nxt          = 1'b1;
      out_data_nxt           = '0;
      out_data_nxt.overwrote = full_r;
    end else if (in_acc && !cmd.start) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
    end else if (res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  rbol_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_idx_r),
    .wdata({in_data.entry_handle, in_data.entry_size}),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  rbol_walk u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .busy     (walk_busy),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .res_valid(res_valid),
    .res      (res),
    .res_ready(res_ready)
  );

  a_full_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    $past(full_r) |-> full_r)
    else $error("full flag dropped");

  a_rd_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    !full_r |-> (rd_idx_r == '0))
    else $error("read index moved before ring filled");

  a_full_eq: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (wr_idx_r == rd_idx_r))
    else $error("full ring with unequal indices");

  a_no_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
    walk_busy |-> !in_ready)
    else $error("item accepted during walk");

endmodule

`default_nettype wire

FILE: bench/ring_buffer_offset_lookup_tb.sv
`default_nettype none

// Track the ring contents and queue the answer owed for each accepted item
class offset_ring_board;
  logic [rbol_pkg::HANDLE_W-1:0] ring_handles [rbol_pkg::DEPTH];
  logic [rbol_pkg::SIZE_W-1:0]   ring_sizes [rbol_pkg::DEPTH];
  int                            oldest;
  int                            next_free;
  bit                            full;
  rbol_pkg::rbol_out_t           pending_answers [$];
  int                            error_count;

  function new();
    oldest = 0;
    next_free = 0;
    full = 1'b0;
    error_count = 0;
  endfunction

  function int step_slot(int s);
    return (s + 1 >= rbol_pkg::DEPTH) ? 0 : s + 1;
  endfunction

  function int live_count();
    if (full)
      return rbol_pkg::DEPTH;
    if (next_free >= oldest)
      return next_free - oldest;
    return next_free + rbol_pkg::DEPTH - oldest;
  endfunction

  // Sum the lengths of the k oldest entries
  function int prefix_bytes(int k);
    int sum;
    int s;
    int n;
    sum = 0;
    s = oldest;
    for (n = 0; n < k; n++) begin
      sum += ring_sizes[s];
      s = step_slot(s);
    end
    return sum;
  endfunction

  // Apply an accepted item to the ring and queue its answer
  function void note_item(rbol_pkg::rbol_in_t item);
    rbol_pkg::rbol_out_t ans;
    int s;
    int n;
    int cnt;
    int left;
    ans = '0;
    if (item.opcode == rbol_pkg::OP_ADD) begin
      // Drop the oldest entry when the ring is already full
      if (full) begin
        oldest = step_slot(oldest);
        ans.overwrote = 1'b1;
      end
      ring_handles[next_free] = item.entry_handle;
      ring_sizes[next_free] = item.entry_size;
      next_free = step_slot(next_free);
      if (next_free == oldest)
        full = 1'b1;
    end else begin
      // Walk oldest first, subtracting lengths until the byte falls inside one
      s = oldest;
      left = int'(item.find_offset);
      cnt = live_count();
      for (n = 0; n < cnt && !ans.found; n++) begin
        if (left < ring_sizes[s]) begin
          ans.found = 1'b1;
          ans.found_handle = ring_handles[s];
          ans.found_size = ring_sizes[s];
          ans.byte_offset = left[15:0];
        end else begin
          left -= ring_sizes[s];
          s = step_slot(s);
        end
      end
    end
    pending_answers.push_back(ans);
  endfunction

  // Compare a delivered result with the oldest answer owed
  function void check_item(rbol_pkg::rbol_out_t got);
    rbol_pkg::rbol_out_t want;
    if (pending_answers.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("[%0t] result with nothing pending: found=%0d handle=%h size=%h offs=%h ovw=%0d",
                 $realtime, got.found, got.found_handle, got.found_size, got.byte_offset,
                 got.overwrote);
    end else begin
      want = pending_answers.pop_front();
      if (got.found !== want.found || got.found_handle !== want.found_handle ||
          got.found_size !== want.found_size || got.byte_offset !== want.byte_offset ||
          got.overwrote !== want.overwrote) begin
        error_count++;
        if (error_count <= 10) begin
          $display("[%0t] mismatch, expected: found=%0d handle=%h size=%h offs=%h ovw=%0d",
                   $realtime, want.found, want.found_handle, want.found_size,
                   want.byte_offset, want.overwrote);
          $display("[%0t] mismatch, actual:   found=%0d handle=%h size=%h offs=%h ovw=%0d",
                   $realtime, got.found, got.found_handle, got.found_size,
                   got.byte_offset, got.overwrote);
        end
      end
    end
  endfunction
endclass

module ring_buffer_offset_lookup_tb;
  import rbol_pkg::*;

  localparam int QUIET_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 600;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  rbol_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  rbol_out_t out_data;

  offset_ring_board board;
  bit               steady_run;
  int               quiet_cycles;

  ring_buffer_offset_lookup dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones, none during a steady stretch
  function automatic int pick_gap();
    int r;
    if (steady_run)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic rbol_in_t make_add(logic [HANDLE_W-1:0] h, logic [SIZE_W-1:0] sz);
    rbol_in_t item;
    item.opcode = OP_ADD;
    item.entry_handle = h;
    item.entry_size = sz;
    item.find_offset = OFFS_W'($urandom_range(0, 20'hFFFFF));
    return item;
  endfunction

  function automatic rbol_in_t make_find(logic [OFFS_W-1:0] offs);
    rbol_in_t item;
    item.opcode = OP_FIND;
    item.entry_handle = $urandom;
    item.entry_size = SIZE_W'($urandom_range(0, 16'hFFFF));
    item.find_offset = offs;
    return item;
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      return '0;
    if (r < 45)
      return SIZE_W'($urandom_range(1, 8));
    if (r < 60)
      return 16'hFFFF;
    return SIZE_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // Aim most finds inside the stored data and at entry boundaries
  function automatic logic [OFFS_W-1:0] rand_offset();
    int r;
    int total;
    int k;
    r = $urandom_range(0, 99);
    total = board.prefix_bytes(board.live_count());
    if (r < 25 || total == 0)
      return OFFS_W'($urandom_range(0, 20'hFFFFF));
    if (r < 70)
      return OFFS_W'($urandom_range(0, total - 1));
    k = $urandom_range(1, board.live_count());
    if (r < 85 || board.prefix_bytes(k) == 0)
      return OFFS_W'(board.prefix_bytes(k));
    return OFFS_W'(board.prefix_bytes(k) - 1);
  endfunction

  // Present one item and hold it until accepted
  task automatic send_item(input rbol_in_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold the sender until every owed result has arrived
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (board.pending_answers.size() != 0);
    @(posedge clk);
  endtask

  // Stall the result channel at random
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Record handshakes and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        board.note_item(in_data);
      if (out_valid && out_ready)
        board.check_item(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** ring_buffer_offset_lookup: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int i;
    int total;
    board = new();
    steady_run = 1'b0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Empty ring answers not found
    send_item(make_find('0));
    send_item(make_find(20'hFFFFF));
    // Zero-length entry is never selected
    send_item(make_add('0, '0));
    send_item(make_find('0));
    send_item(make_add(32'hFFFF_FFFF, 16'hFFFF));
    send_item(make_find('0));
    send_item(make_find(20'h0FFFE));
    send_item(make_find(20'h0FFFF));
    send_item(make_add(32'h1234_5678, 16'h0001));
    send_item(make_find(20'h0FFFF));
    // Fill the ring, then overwrite the two oldest
    for (i = 0; i < DEPTH - 3; i++)
      send_item(make_add($urandom, 16'hFFFF));
    send_item(make_add($urandom, 16'hFFFF));
    send_item(make_add($urandom, 16'hFFFF));
    wait_for_results();
    total = board.prefix_bytes(board.live_count());
    send_item(make_find('0));
    send_item(make_find(OFFS_W'(total - 1)));
    send_item(make_find(OFFS_W'(total)));
    send_item(make_find(20'hFFFFF));

    // Random mix of adds and finds with steady stretches and drain pauses
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0)
        steady_run = ($urandom_range(0, 3) == 0);
      if (i % 200 == 100)
        wait_for_results();
      if ($urandom_range(0, 99) < 40)
        send_item(make_add($urandom, rand_size()));
      else
        send_item(make_find(rand_offset()));
    end

    wait_for_results();
    repeat (DEPTH + 4) @(posedge clk);
    if (board.error_count == 0 && board.pending_answers.size() == 0)
      $display("** ring_buffer_offset_lookup: PASSED **");
    else
      $display("** ring_buffer_offset_lookup: FAILED **");
    $finish;
  end
endmodule

`default_nettype wire
